[src/otet_pkg.sv]
// Package for the one-shot timer event table.
// Holds item types, command and status codes, and controller/datapath structs.
// No dependencies.
`default_nettype none

package otet_pkg;

    localparam int DEFAULT_NUM_SLOTS = 8;
    localparam int RESULT_CAP        = 8;
    localparam int CNT_W             = $clog2(RESULT_CAP + 1);

    localparam logic [2:0] CMD_ACTIVATE   = 3'd0;
    localparam logic [2:0] CMD_REACTIVATE = 3'd1;
    localparam logic [2:0] CMD_CANCEL     = 3'd2;
    localparam logic [2:0] CMD_TICK       = 3'd3;
    localparam logic [2:0] CMD_POLL       = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RESTART = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  event_id;
        logic [15:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic       event_fired;
        logic [7:0] fired_event;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  event_id;
        logic [15:0] remaining;
    } slot_word_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic cap_hit;
    } dp_status_t;

endpackage

`default_nettype wire

[src/otet_ctrl.sv]
// Controller state machine of the one-shot timer event table.
// Sequences the slot scan of the datapath; uses otet_pkg.
`default_nettype none

module otet_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output otet_pkg::dp_cmd_t       cmd,
    input  wire otet_pkg::dp_status_t stat
);
    import otet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.cap_hit || stat.last_slot)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.finish = (state_reg == S_FINISH);

endmodule

`default_nettype wire

[src/otet_datapath.sv]
// Datapath of the one-shot timer event table: slot memory, active bits,
// scan index, search flags, pending expiry and result register; uses otet_pkg.
`default_nettype none

module otet_datapath #(
    parameter int NUM_SLOTS = otet_pkg::DEFAULT_NUM_SLOTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire otet_pkg::in_item_t   request,
    input  wire otet_pkg::dp_cmd_t    cmd,
    output otet_pkg::dp_status_t      stat,
    output otet_pkg::out_item_t       result,
    output logic                      result_valid
);
    import otet_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    slot_word_t mem [NUM_SLOTS];
    slot_word_t rdata_reg;

    in_item_t               req_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]   active_reg, active_next;
    logic                   match_found_reg, match_found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]       found_cnt_reg, found_cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [7:0]             pend_event_reg, pend_event_next;
    out_item_t              result_reg, result_next;
    logic                   result_valid_reg, result_valid_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    slot_word_t             mem_wdata;

    logic slot_act;
    logic slot_hit;
    logic slot_expired;
    logic found_now;
    logic [1:0] start_status;

    assign slot_act     = active_reg[idx_reg];
    assign slot_hit     = slot_act && (rdata_reg.event_id == req_reg.event_id);
    assign slot_expired = slot_act && (rdata_reg.remaining == 16'd0);
    assign found_now    = cmd.eval && (req_reg.command == CMD_POLL) && slot_expired;

    assign stat.last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign stat.cap_hit   = found_now && (found_cnt_reg == CNT_W'(RESULT_CAP - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            found_cnt_reg    <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            active_reg       <= active_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            match_found_reg  <= match_found_next;
            free_found_reg   <= free_found_next;
            found_cnt_reg    <= found_cnt_next;
            idx_reg          <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        pend_event_reg <= pend_event_next;
        result_reg     <= result_next;
    end

    always_comb
    begin
        idx_next          = idx_reg;
        active_next       = active_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        found_cnt_next    = found_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_event_next   = pend_event_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = rdata_reg;
        start_status      = ST_OK;

        if (match_found_reg)
        begin
            start_status = ST_DUP;
        end
        else if (!free_found_reg)
        begin
            start_status = ST_FULL;
        end

        if (cmd.load)
        begin
            idx_next         = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            found_cnt_next   = '0;
            pend_valid_next  = 1'b0;
        end
        else if (cmd.eval)
        begin
            idx_next = IDX_W'(idx_reg + 1'b1);
            case (req_reg.command)
                CMD_ACTIVATE, CMD_REACTIVATE:
                begin
                    if (slot_hit && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = idx_reg;
                    end
                    if (!slot_act && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                end
                CMD_CANCEL:
                begin
                    if (slot_hit)
                    begin
                        active_next[idx_reg] = 1'b0;
                    end
                end
                CMD_TICK:
                begin
                    if (slot_act && (rdata_reg.remaining != 16'd0))
                    begin
                        mem_we              = 1'b1;
                        mem_waddr           = idx_reg;
                        mem_wdata.event_id  = rdata_reg.event_id;
                        mem_wdata.remaining = 16'(rdata_reg.remaining - 16'd1);
                    end
                end
                CMD_POLL:
                begin
                    if (slot_expired)
                    begin
                        active_next[idx_reg] = 1'b0;
                        if (pend_valid_reg)
                        begin
                            result_valid_next       = 1'b1;
                            result_next.event_fired = 1'b1;
                            result_next.fired_event = pend_event_reg;
                            result_next.status      = ST_OK;
                            result_next.last        = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_event_next = rdata_reg.event_id;
                        found_cnt_next  = CNT_W'(found_cnt_reg + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.finish)
        begin
            result_valid_next       = 1'b1;
            result_next.event_fired = 1'b0;
            result_next.fired_event = 8'd0;
            result_next.status      = ST_OK;
            result_next.last        = 1'b1;
            mem_wdata.event_id      = req_reg.event_id;
            mem_wdata.remaining     = req_reg.time_value;
            case (req_reg.command)
                CMD_ACTIVATE:
                begin
                    result_next.status = start_status;
                    if (!match_found_reg && free_found_reg)
                    begin
                        mem_we                    = 1'b1;
                        mem_waddr                 = free_idx_reg;
                        active_next[free_idx_reg] = 1'b1;
                    end
                end
                CMD_REACTIVATE:
                begin
                    if (match_found_reg)
                    begin
                        result_next.status = ST_RESTART;
                        mem_we             = 1'b1;
                        mem_waddr          = match_idx_reg;
                    end
                    else
                    begin
                        result_next.status = start_status;
                        if (free_found_reg)
                        begin
                            mem_we                    = 1'b1;
                            mem_waddr                 = free_idx_reg;
                            active_next[free_idx_reg] = 1'b1;
                        end
                    end
                end
                CMD_POLL:
                begin
                    if (pend_valid_reg)
                    begin
                        result_next.event_fired = 1'b1;
                        result_next.fired_event = pend_event_reg;
                    end
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

[src/one_shot_timer_event_table.sv]
// Top level of the one-shot timer event table.
// Instantiates otet_ctrl and otet_datapath; uses otet_pkg.
//
// channel   signals                      handshake
// --------  ---------------------------  ---------------------------------
// request   request (in_item_t)          taken when start && !busy
// result    result (out_item_t)          valid for one cycle on result_valid
//
// From accept until busy falls, an item reads and then evaluates every slot in
// turn through the single registered read port of the slot memory, then passes
// a finish state. A poll that reaches eight expiries ends its scan at that slot.
// Results leave through an output register, so the final result shows in the
// first idle cycle. Reset frees every slot at once.
// The result side has no stall; the request side waits on busy.
`default_nettype none

module one_shot_timer_event_table #(
    parameter int NUM_SLOTS = otet_pkg::DEFAULT_NUM_SLOTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire otet_pkg::in_item_t request,
    output otet_pkg::out_item_t     result,
    output logic                    result_valid
);
    import otet_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    otet_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    otet_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

[src/otet_checker.sv]
// Port-level checker for the one-shot timer event table, bound to the top.
// Uses otet_pkg.
`default_nettype none

module otet_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire otet_pkg::out_item_t result,
    input wire logic                result_valid
);
    import otet_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after an accepted item");

    a_more_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("non-final result while idle");

    a_nonfinal_is_fired: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.event_fired)
        else $error("non-final result without an expired event");

    a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.event_fired |-> result.fired_event == 8'd0)
        else $error("event id set on a result without expiry");

    a_fired_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.event_fired |-> result.status == ST_OK)
        else $error("expiry result with nonzero status");

endmodule

bind one_shot_timer_event_table otet_checker u_otet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);

`default_nettype wire

[verif/one_shot_timer_event_table_test.sv]
`timescale 1ns / 1ps
// Testbench for one_shot_timer_event_table: directed and random command items,
// each result checked against an in-bench model of the timer slots.
// Depends on otet_pkg and the one_shot_timer_event_table RTL.

module one_shot_timer_event_table_test;

    import otet_pkg::*;

    localparam int NUM_SLOTS = DEFAULT_NUM_SLOTS;
    localparam int ITEM_CYCLES = 2 * NUM_SLOTS + 2;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 385;
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t request;
    out_item_t result;
    logic result_valid;

    logic timer_live [NUM_SLOTS];
    logic [15:0] timer_count [NUM_SLOTS];
    logic [7:0] timer_event [NUM_SLOTS];

    out_item_t pending_outcomes [$];
    out_item_t want;

    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int expiries_seen = 0;
    int full_seen = 0;
    int restarts_seen = 0;
    int idle_cycles = 0;

    one_shot_timer_event_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result(result),
        .result_valid(result_valid)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic in_item_t make_item(input logic [2:0] cmd, input logic [7:0] ev,
                                           input logic [15:0] ticks);
        in_item_t item;
        item.command = cmd;
        item.event_id = ev;
        item.time_value = ticks;
        return item;
    endfunction

    function automatic int find_live(input logic [7:0] ev);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (timer_live[i] && timer_event[i] == ev)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [1:0] arm_timer(input logic [7:0] ev, input logic [15:0] ticks);
        if (find_live(ev) >= 0)
            return ST_DUP;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!timer_live[i])
            begin
                timer_live[i] = 1'b1;
                timer_count[i] = ticks;
                timer_event[i] = ev;
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    function automatic void apply_command(input in_item_t item);
        out_item_t r;
        int slot;
        int n;
        r = '0;
        r.last = 1'b1;
        case (item.command)
            CMD_ACTIVATE:
                r.status = arm_timer(item.event_id, item.time_value);
            CMD_REACTIVATE:
            begin
                slot = find_live(item.event_id);
                if (slot >= 0)
                begin
                    timer_count[slot] = item.time_value;
                    r.status = ST_RESTART;
                end
                else
                    r.status = arm_timer(item.event_id, item.time_value);
            end
            CMD_CANCEL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (timer_live[i] && timer_event[i] == item.event_id)
                        timer_live[i] = 1'b0;
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (timer_live[i] && timer_count[i] != 16'd0)
                        timer_count[i] = timer_count[i] - 16'd1;
                end
            end
            CMD_POLL:
            begin
                n = 0;
                for (int i = 0; i < NUM_SLOTS && n < RESULT_CAP; i++)
                begin
                    if (timer_live[i] && timer_count[i] == 16'd0)
                    begin
                        timer_live[i] = 1'b0;
                        r.event_fired = 1'b1;
                        r.fired_event = timer_event[i];
                        r.status = ST_OK;
                        r.last = 1'b0;
                        pending_outcomes.push_back(r);
                        n++;
                    end
                end
                if (n > 0)
                begin
                    pending_outcomes[pending_outcomes.size() - 1].last = 1'b1;
                    return;
                end
                r = '0;
                r.last = 1'b1;
            end
            default:
                r.status = ST_OK;
        endcase
        pending_outcomes.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] exp);
        $display("MISMATCH at %0t: %s got %h, expected %h", $realtime, field, got, exp);
        error_count++;
    endtask

    // hold start high until the item is taken
    task automatic send_item(input in_item_t item);
        request <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        apply_command(item);
        items_sent++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic in_item_t random_item();
        int pick;
        logic [2:0] cmd;
        logic [7:0] ev;
        logic [15:0] ticks;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            cmd = CMD_ACTIVATE;
        else if (pick < 38)
            cmd = CMD_REACTIVATE;
        else if (pick < 47)
            cmd = CMD_CANCEL;
        else if (pick < 72)
            cmd = CMD_TICK;
        else if (pick < 95)
            cmd = CMD_POLL;
        else
            cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        if ($urandom_range(0, 99) < 85)
            ev = 8'($urandom_range(0, 11));
        else
            ev = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            ticks = 16'($urandom_range(0, 3));
        else if (pick < 9)
            ticks = 16'($urandom_range(0, 20));
        else
            ticks = 16'($urandom_range(0, 65535));
        return make_item(cmd, ev, ticks);
    endfunction

    task automatic test_empty_and_duplicate();
        send_item(make_item(CMD_POLL, 8'h00, 16'h0000));
        send_item(make_item(CMD_ACTIVATE, 8'h00, 16'h0000));
        send_item(make_item(CMD_ACTIVATE, 8'h00, 16'h0005));
        send_item(make_item(CMD_REACTIVATE, 8'h00, 16'hFFFF));
        send_item(make_item(CMD_TICK, 8'hA5, 16'h1234));
        send_item(make_item(CMD_POLL, 8'hFF, 16'hFFFF));
    endtask

    task automatic test_table_full();
        send_item(make_item(CMD_ACTIVATE, 8'hFF, 16'h0000));
        for (int ev = 1; ev <= 6; ev++)
            send_item(make_item(CMD_ACTIVATE, ev[7:0], 16'h0000));
        send_item(make_item(CMD_ACTIVATE, 8'h80, 16'h0001));
        send_item(make_item(CMD_REACTIVATE, 8'h81, 16'h0002));
        send_item(make_item(CMD_ACTIVATE, 8'hFF, 16'h0003));
    endtask

    task automatic test_cancel_and_rearm();
        send_item(make_item(CMD_CANCEL, 8'h00, 16'h0000));
        send_item(make_item(CMD_CANCEL, 8'h42, 16'hFFFF));
        send_item(make_item(CMD_REACTIVATE, 8'h80, 16'h0000));
    endtask

    task automatic test_poll_flood();
        send_item(make_item(CMD_POLL, 8'h00, 16'h0000));
        send_item(make_item(CMD_POLL, 8'h00, 16'h0000));
    endtask

    task automatic test_unused_commands();
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_item(make_item(c[2:0], 8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535))));
    endtask

    task automatic test_random_traffic();
        int counted;
        int burst;
        in_item_t item;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                item = random_item();
                send_item(item);
                if (item.command <= CMD_POLL)
                    counted++;
            end
            if (counted % 100 < burst)
                hold_until_drained();
            else if ($urandom_range(0, 3) == 0)
                idle_for(0);
            else
                idle_for($urandom_range(1, ITEM_CYCLES + 2));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (result.event_fired === 1'b1)
                expiries_seen++;
            if (result.status === ST_FULL)
                full_seen++;
            if (result.status === ST_RESTART)
                restarts_seen++;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected result", 16'(result), 16'd0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.event_fired !== want.event_fired)
                    report_mismatch("event_fired", 16'(result.event_fired),
                                    16'(want.event_fired));
                if (result.fired_event !== want.fired_event)
                    report_mismatch("fired_event", 16'(result.fired_event),
                                    16'(want.fired_event));
                if (result.status !== want.status)
                    report_mismatch("status", 16'(result.status), 16'(want.status));
                if (result.last !== want.last)
                    report_mismatch("last", 16'(result.last), 16'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("stalled for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            timer_live[i] = 1'b0;
            timer_count[i] = 16'd0;
            timer_event[i] = 8'd0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_duplicate();
        test_table_full();
        test_cancel_and_rearm();
        test_poll_flood();
        test_unused_commands();
        hold_until_drained();
        test_random_traffic();

        hold_until_drained();
        repeat (ITEM_CYCLES + 4) @(posedge clk);

        $display("ran %0d command items; checked %0d results", items_sent, results_seen);
        $display("  %0d expiries, %0d full-table and %0d restart replies",
                 expiries_seen, full_seen, restarts_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
